@@ rtl/core/tvs_pkg.sv @@
package tvs_pkg;

  // Volume geometry and number formats
  localparam int MaxX      = 32;
  localparam int MaxY      = 32;
  localparam int MaxZ      = 32;
  localparam int VoxelBits = 16;
  localparam int FracBits  = 8;
  localparam int PosBits   = 14;
  localparam int IdxBits   = 5;
  localparam int SizeBits  = 6;
  localparam int OutBits   = 24;

  // Per-bank depth: volume split eight ways by index parity
  localparam int BankAddrBits = 3 * (IdxBits - 1);
  localparam int BankDepth    = 1 << BankAddrBits;

  // Partial sum widths after each interpolation pass
  localparam int WgtBits  = FracBits + 1;
  localparam int LerpZBits = VoxelBits + FracBits;
  localparam int LerpYBits = VoxelBits + 2 * FracBits;
  localparam int LerpXBits = VoxelBits + 3 * FracBits;

  typedef enum logic [1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } reg_idx_t;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  // Clamp a size register to the axis maximum
  function automatic logic [SizeBits-1:0] eff_size(input logic [SizeBits-1:0] r,
                                                   input logic [SizeBits-1:0] m);
    eff_size = (r > m) ? m : r;
  endfunction

  // Position lies in [0, size-1) on one axis
  function automatic logic axis_inside(input logic [PosBits-1:0] p,
                                       input logic [SizeBits-1:0] sz);
    logic [SizeBits-1:0] ip1;
    ip1 = {1'b0, p[PosBits-2:FracBits]} + SizeBits'(1);
    axis_inside = !p[PosBits-1] && (ip1 < sz);
  endfunction

endpackage

@@ rtl/core/trilinear_volume_sampler.sv @@
// Trilinear volume sampler, eight-bank voxel store, six register stages.
// Samples pass in order through the input, range, bank-read, z, y and output stages.
// Throughput: one transfer per cycle while in_stall is low; writes and samples
// mix freely; a voxel write is visible to any sample accepted in a later cycle.
// Reset: synchronous active-low rst_n clears valid bits and sets sizes to 32;
// voxel contents are undefined until written.
module trilinear_volume_sampler
  import tvs_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // item input
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_op,
  input  logic [IdxBits-1:0]   in_wr_x,
  input  logic [IdxBits-1:0]   in_wr_y,
  input  logic [IdxBits-1:0]   in_wr_z,
  input  logic [VoxelBits-1:0] in_voxel_value,
  input  logic signed [PosBits-1:0] in_pos_x,
  input  logic signed [PosBits-1:0] in_pos_y,
  input  logic signed [PosBits-1:0] in_pos_z,
  // result output
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [OutBits-1:0]   out_sample_value,
  output logic                 out_in_range,
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [SizeBits-1:0]  cfg_data
);

  // ---------------------------------------------------------------------------
  // Size registers. Always ready; indexes past the list are dropped.
  // ---------------------------------------------------------------------------
  logic [SizeBits-1:0] size_x_r, size_y_r, size_z_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_x_r <= SizeBits'(32);
      size_y_r <= SizeBits'(32);
      size_z_r <= SizeBits'(32);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SIZE_X: size_x_r <= cfg_data;
        REG_SIZE_Y: size_y_r <= cfg_data;
        REG_SIZE_Z: size_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Whole pipeline moves together; it freezes only when a finished result
  // sits in the output register and the consumer stalls.
  // ---------------------------------------------------------------------------
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // Stage 1: input register
  logic                 vld1_r, op1_r;
  logic [IdxBits-1:0]   wx1_r, wy1_r, wz1_r;
  logic [VoxelBits-1:0] val1_r;
  logic [PosBits-1:0]   px1_r, py1_r, pz1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld1_r <= 1'b0;
    else if (en) vld1_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r  <= in_op;
      wx1_r  <= in_wr_x;
      wy1_r  <= in_wr_y;
      wz1_r  <= in_wr_z;
      val1_r <= in_voxel_value;
      px1_r  <= in_pos_x;
      py1_r  <= in_pos_y;
      pz1_r  <= in_pos_z;
    end
  end

  // Stage 2: range check, split position into base cell and fraction
  logic inr1;
  assign inr1 = axis_inside(px1_r, eff_size(size_x_r, SizeBits'(MaxX))) &&
                axis_inside(py1_r, eff_size(size_y_r, SizeBits'(MaxY))) &&
                axis_inside(pz1_r, eff_size(size_z_r, SizeBits'(MaxZ)));

  logic                 vld2_r, op2_r, inr2_r;
  logic [IdxBits-1:0]   wx2_r, wy2_r, wz2_r;
  logic [VoxelBits-1:0] val2_r;
  logic [IdxBits-1:0]   bx2_r, by2_r, bz2_r;
  logic [FracBits-1:0]  fx2_r, fy2_r, fz2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld2_r <= 1'b0;
    else if (en) vld2_r <= vld1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2_r  <= op1_r;
      inr2_r <= inr1;
      wx2_r  <= wx1_r;
      wy2_r  <= wy1_r;
      wz2_r  <= wz1_r;
      val2_r <= val1_r;
      bx2_r  <= px1_r[FracBits+IdxBits-1:FracBits];
      by2_r  <= py1_r[FracBits+IdxBits-1:FracBits];
      bz2_r  <= pz1_r[FracBits+IdxBits-1:FracBits];
      fx2_r  <= px1_r[FracBits-1:0];
      fy2_r  <= py1_r[FracBits-1:0];
      fz2_r  <= pz1_r[FracBits-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Voxel store: eight banks selected by (z,y,x) index parity, so the eight
  // corners of any cell land in distinct banks and are read in the same cycle.
  // Writes and reads share this stage, keeping program order.
  // ---------------------------------------------------------------------------
  logic [IdxBits-1:0]   bx1p, by1p, bz1p;
  logic [2:0]           wr_bank;
  logic [BankAddrBits-1:0] wr_addr;
  logic                 wr_en;
  logic [VoxelBits-1:0] rd_q [8];

  assign bx1p    = bx2_r + IdxBits'(1);
  assign by1p    = by2_r + IdxBits'(1);
  assign bz1p    = bz2_r + IdxBits'(1);
  assign wr_bank = {wz2_r[0], wy2_r[0], wx2_r[0]};
  assign wr_addr = {wz2_r[IdxBits-1:1], wy2_r[IdxBits-1:1], wx2_r[IdxBits-1:1]};
  assign wr_en   = en && vld2_r && (op2_r == OP_WRITE);

  for (genvar b = 0; b < 8; b++) begin : g_bank
    logic [VoxelBits-1:0]    mem [BankDepth];
    logic [IdxBits-1:0]      cx, cy, cz;
    logic [BankAddrBits-1:0] rd_addr;

    // corner coordinate whose parity matches this bank
    assign cx = (bx2_r[0] == b[0]) ? bx2_r : bx1p;
    assign cy = (by2_r[0] == b[1]) ? by2_r : by1p;
    assign cz = (bz2_r[0] == b[2]) ? bz2_r : bz1p;
    assign rd_addr = {cz[IdxBits-1:1], cy[IdxBits-1:1], cx[IdxBits-1:1]};

    always_ff @(posedge clk) begin
      if (wr_en && (wr_bank == 3'(b))) mem[wr_addr] <= val2_r;
      if (en) rd_q[b] <= mem[rd_addr];
    end
  end

  // Stage 3: bank data registered; carry weights and parity
  logic                vld3_r, inr3_r;
  logic [2:0]          par3_r;
  logic [FracBits-1:0] fx3_r, fy3_r, fz3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) vld3_r <= 1'b0;
    else if (en) vld3_r <= vld2_r && (op2_r == OP_SAMPLE);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inr3_r <= inr2_r;
      par3_r <= {bz2_r[0], by2_r[0], bx2_r[0]};
      fx3_r  <= fx2_r;
      fy3_r  <= fy2_r;
      fz3_r  <= fz2_r;
    end
  end

  // Pass along z: corner c has offsets {dz,dy,dx}; its bank is c ^ parity
  logic [VoxelBits-1:0] corner [8];
  logic [WgtBits-1:0]   wz0;
  logic [LerpZBits-1:0] lz [4];

  assign wz0 = (WgtBits'(1) << FracBits) - WgtBits'(fz3_r);

  always_comb begin
    for (int c = 0; c < 8; c++) corner[c] = rd_q[3'(c) ^ par3_r];
    for (int j = 0; j < 4; j++) begin
      lz[j] = LerpZBits'(corner[j] * wz0 + corner[j+4] * WgtBits'(fz3_r));
    end
  end

  // Stage 4
  logic                 vld4_r, inr4_r;
  logic [FracBits-1:0]  fx4_r, fy4_r;
  logic [LerpZBits-1:0] lz4_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) vld4_r <= 1'b0;
    else if (en) vld4_r <= vld3_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inr4_r <= inr3_r;
      fx4_r  <= fx3_r;
      fy4_r  <= fy3_r;
      lz4_r  <= lz;
    end
  end

  // Pass along y
  logic [WgtBits-1:0]   wy0;
  logic [LerpYBits-1:0] ly [2];

  assign wy0 = (WgtBits'(1) << FracBits) - WgtBits'(fy4_r);

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      ly[j] = LerpYBits'(lz4_r[j] * wy0 + lz4_r[j+2] * WgtBits'(fy4_r));
    end
  end

  // Stage 5
  logic                 vld5_r, inr5_r;
  logic [FracBits-1:0]  fx5_r;
  logic [LerpYBits-1:0] ly5_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) vld5_r <= 1'b0;
    else if (en) vld5_r <= vld4_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inr5_r <= inr4_r;
      fx5_r  <= fx4_r;
      ly5_r  <= ly;
    end
  end

  // Pass along x, then drop 2*FracBits of weight scaling (floor)
  logic [WgtBits-1:0]   wx0;
  logic [LerpXBits-1:0] lx;

  assign wx0 = (WgtBits'(1) << FracBits) - WgtBits'(fx5_r);
  assign lx  = LerpXBits'(ly5_r[0] * wx0 + ly5_r[1] * WgtBits'(fx5_r));

  // Stage 6: output register
  logic                 out_valid_r, out_in_range_r;
  logic [OutBits-1:0]   out_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= vld5_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_in_range_r <= inr5_r;
      out_value_r    <= inr5_r ? lx[2*FracBits+OutBits-1:2*FracBits] : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_in_range     = out_in_range_r;
  assign out_sample_value = out_value_r;

`ifndef SYNTH
  // Out-of-range samples always report zero
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_in_range) |-> (out_sample_value == '0))
    else $error("out-of-range sample with nonzero value");

  // An in-range base cell never sits on the last index (corner +1 must not wrap)
  a_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (vld2_r && inr2_r) |-> (bx2_r != '1 && by2_r != '1 && bz2_r != '1))
    else $error("in-range cell at volume edge");

  // A sample in the last stage reaches the output on the next advance
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (vld5_r && en) |=> out_valid)
    else $error("sample lost before output");
`endif

endmodule
